// ===== rtl/core/pdm_pkg.sv =====
// Shared constants, types and state encodings for the PWM period/duty meter.
package pdm_pkg;

  localparam int STAMP_W    = 16;                // width of the stamp field
  localparam int STAMP_BITS = 16;                // stamp bits actually used
  localparam int PER_W      = STAMP_BITS + 1;    // high + low
  localparam int TICK_W     = 24;
  localparam int DIV_W      = 24;                // dividend width of both divisions
  localparam int CNT_W      = $clog2(DIV_W);
  localparam int FREQ_W     = 16;
  localparam int DUTY_W     = 7;
  localparam int QDEPTH     = 2;
  localparam int QIDX_W     = $clog2(QDEPTH);

  localparam logic [DIV_W-1:0]  PCT        = DIV_W'(100);
  localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(1000000);
  localparam logic [FREQ_W-1:0] FREQ_MAX   = {FREQ_W{1'b1}};

  localparam logic CMD_START = 1'b0;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RISE1,
    PH_FALL,
    PH_RISE2
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DONE
  } back_st_t;

  typedef struct packed {
    logic [STAMP_BITS-1:0] high;
    logic [STAMP_BITS-1:0] low;
  } job_t;

endpackage

// ===== rtl/core/pdm_if.sv =====
// Channel interfaces: edge events in, measurement results out, config writes.
interface pdm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic                        edge_rising;
  logic [pdm_pkg::STAMP_W-1:0] stamp;
  modport source (output valid, cmd, edge_rising, stamp, input ready);
  modport sink   (input valid, cmd, edge_rising, stamp, output ready);
endinterface

interface pdm_out_if;
  logic                        valid;
  logic                        ready;
  logic [pdm_pkg::FREQ_W-1:0]  frequency;
  logic [pdm_pkg::DUTY_W-1:0]  duty_percent;
  logic                        zero_period;
  modport source (output valid, frequency, duty_percent, zero_period, input ready);
  modport sink   (input valid, frequency, duty_percent, zero_period, output ready);
endinterface

interface pdm_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [pdm_pkg::TICK_W-1:0]  data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/pwm_period_duty_meter.sv =====
// Top level: PWM period/duty meter from timestamped edge beats.
// The closing rising-edge beat pushes a job into the queue; the back end loads
// it, runs a 24-step restoring division, registers the result beat and only
// then takes a new job. Beats are accepted only while the queue has room.
// A two-entry job queue lets the front keep taking beats while dividing.
// Reset: synchronous active-low rst_n; phase idle, stamps zero, tick rate 1000000.
module pwm_period_duty_meter (
  input  logic       clk,
  input  logic       rst_n,
  pdm_in_if.sink     in_ch,
  pdm_out_if.source  out_ch,
  pdm_cfg_if.sink    cfg_ch
);
  import pdm_pkg::*;

  logic f_valid, f_ready;
  job_t f_job;
  logic b_valid, b_ready;
  job_t b_job;

  pdm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  pdm_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_job),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_job)
  );

  pdm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (b_valid),
    .job_ready (b_ready),
    .job       (b_job),
    .cfg_ch    (cfg_ch),
    .out_ch    (out_ch)
  );

endmodule

// ===== rtl/core/pdm_front.sv =====
// Front end: edge sequencing, stamp capture, high/low time extraction.
module pdm_front (
  input  logic           clk,
  input  logic           rst_n,
  pdm_in_if.sink         in_ch,
  output logic           job_valid,
  input  logic           job_ready,
  output pdm_pkg::job_t  job
);
  import pdm_pkg::*;

  phase_t                phase_r, phase_nxt;
  logic [STAMP_BITS-1:0] rise_r, rise_nxt;
  logic [STAMP_BITS-1:0] fall_r, fall_nxt;
  logic [STAMP_BITS-1:0] st;
  logic                  acc;

  assign in_ch.ready = job_ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign st          = in_ch.stamp[STAMP_BITS-1:0];

  assign job.high = fall_r - rise_r;
  assign job.low  = st - fall_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      rise_r  <= '0;
      fall_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      rise_r  <= rise_nxt;
      fall_r  <= fall_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    rise_nxt  = rise_r;
    fall_nxt  = fall_r;
    job_valid = 1'b0;
    if (acc) begin
      if (in_ch.cmd == CMD_START) begin
        phase_nxt = PH_RISE1;
      end else begin
        unique case (phase_r)
          PH_RISE1: if (in_ch.edge_rising) begin
            rise_nxt  = st;
            phase_nxt = PH_FALL;
          end
          PH_FALL: if (!in_ch.edge_rising) begin
            fall_nxt  = st;
            phase_nxt = PH_RISE2;
          end
          PH_RISE2: if (in_ch.edge_rising) begin
            job_valid = 1'b1;
            phase_nxt = PH_IDLE;
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end
  end

endmodule

// ===== rtl/core/pdm_fifo.sv =====
// Two-entry job queue between the front end and the divider back end.
module pdm_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  pdm_pkg::job_t  wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output pdm_pkg::job_t  rd_data
);
  import pdm_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QIDX_W-1:0] wp_r, rp_r;
  logic [QIDX_W:0]   cnt_r;
  logic              push, pop;

  assign wr_ready = cnt_r != (QIDX_W+1)'(QDEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== rtl/core/pdm_back.sv =====
// Back end: two restoring dividers run in lockstep for duty and frequency.
module pdm_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  output logic           job_ready,
  input  pdm_pkg::job_t  job,
  pdm_cfg_if.sink        cfg_ch,
  pdm_out_if.source      out_ch
);
  import pdm_pkg::*;

  back_st_t          st_r, st_nxt;
  logic [TICK_W-1:0] tick_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIV_W-1:0]  dd_r, dd_nxt;     // duty dividend, quotient shifts in
  logic [DIV_W-1:0]  df_r, df_nxt;     // frequency dividend/quotient
  logic [PER_W-1:0]  per_r, per_nxt;
  logic [PER_W-1:0]  remd_r, remd_nxt;
  logic [PER_W-1:0]  remf_r, remf_nxt;
  logic              zero_r, zero_nxt;
  logic              ov_r, ov_nxt;
  logic [FREQ_W-1:0] freq_r, freq_nxt;
  logic [DUTY_W-1:0] duty_r, duty_nxt;
  logic              zp_r, zp_nxt;

  logic [PER_W:0]    shd, shf;
  logic              bd, bf;
  logic [PER_W-1:0]  sum;
  logic              out_free;

  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = ov_r;
  assign out_ch.frequency    = freq_r;
  assign out_ch.duty_percent = duty_r;
  assign out_ch.zero_period  = zp_r;
  assign out_free            = !ov_r || out_ch.ready;
  assign job_ready           = st_r == BK_IDLE;

  assign sum = {1'b0, job.high} + {1'b0, job.low};
  assign shd = {remd_r, dd_r[DIV_W-1]};
  assign shf = {remf_r, df_r[DIV_W-1]};
  assign bd  = shd >= {1'b0, per_r};
  assign bf  = shf >= {1'b0, per_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= BK_IDLE;
      ov_r   <= 1'b0;
      tick_r <= TICK_RESET;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      if (cfg_ch.valid) tick_r <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    dd_r   <= dd_nxt;
    df_r   <= df_nxt;
    per_r  <= per_nxt;
    remd_r <= remd_nxt;
    remf_r <= remf_nxt;
    zero_r <= zero_nxt;
    freq_r <= freq_nxt;
    duty_r <= duty_nxt;
    zp_r   <= zp_nxt;
  end

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    dd_nxt   = dd_r;
    df_nxt   = df_r;
    per_nxt  = per_r;
    remd_nxt = remd_r;
    remf_nxt = remf_r;
    zero_nxt = zero_r;
    freq_nxt = freq_r;
    duty_nxt = duty_r;
    zp_nxt   = zp_r;
    ov_nxt   = ov_r && !out_ch.ready;
    unique case (st_r)
      BK_IDLE: if (job_valid) begin
        dd_nxt   = DIV_W'(job.high) * PCT;
        df_nxt   = DIV_W'(tick_r);
        per_nxt  = sum;
        zero_nxt = sum == '0;
        remd_nxt = '0;
        remf_nxt = '0;
        cnt_nxt  = '0;
        st_nxt   = BK_RUN;
      end
      BK_RUN: begin
        remd_nxt = bd ? PER_W'(shd - {1'b0, per_r}) : shd[PER_W-1:0];
        remf_nxt = bf ? PER_W'(shf - {1'b0, per_r}) : shf[PER_W-1:0];
        dd_nxt   = {dd_r[DIV_W-2:0], bd};
        df_nxt   = {df_r[DIV_W-2:0], bf};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W-1)) st_nxt = BK_DONE;
      end
      BK_DONE: if (out_free) begin
        ov_nxt = 1'b1;
        zp_nxt = zero_r;
        if (zero_r) begin
          freq_nxt = '0;
          duty_nxt = '0;
        end else begin
          freq_nxt = (|df_r[DIV_W-1:FREQ_W]) ? FREQ_MAX : df_r[FREQ_W-1:0];
          duty_nxt = dd_r[DUTY_W-1:0];
        end
        st_nxt = BK_IDLE;
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

endmodule
